// ===== rtl/core/gpe_pkg.sv =====
// ----------------------------------------------------------------------------
// gpe_pkg
// Shared widths, register indexes and the command record that passes from
// the front end through the command queue to the pixel engine.
// ----------------------------------------------------------------------------
`default_nettype none

package gpe_pkg;

  // Character cell geometry.
  localparam int CELL_SIZE = 8;
  localparam int CELL_W    = $clog2(CELL_SIZE);

  // Field widths.
  localparam int GLYPH_W = CELL_SIZE * CELL_SIZE;
  localparam int COORD_W = 12;
  localparam int DIM_W   = 13;
  localparam int ADDR_W  = 24;
  localparam int COLOR_W = 32;

  // Stream widths.
  localparam int S_TDATA_W = GLYPH_W + 2 * COORD_W + 2 * COLOR_W;
  localparam int M_TDATA_W = 64;

  // Configuration port.
  localparam int                 CFG_IDX_W        = 2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [DIM_W-1:0]   FRAME_WIDTH_RST  = 13'd1024;
  localparam logic [DIM_W-1:0]   FRAME_HEIGHT_RST = 13'd768;

  // Dirty list.
  localparam int DIRTY_DEPTH  = 16;
  localparam int DIRTY_FILL_W = $clog2(DIRTY_DEPTH + 1);
  localparam int DIRTY_IDX_W  = (DIRTY_DEPTH > 1) ? $clog2(DIRTY_DEPTH) : 1;

  // Command queue between front end and pixel engine.
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // One accepted draw command with its precomputed first row base address.
  typedef struct packed {
    logic [GLYPH_W-1:0] glyph_rows;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic [COLOR_W-1:0] fg_color;
    logic [COLOR_W-1:0] bg_color;
    logic [ADDR_W-1:0]  row_base;
  } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/gpe_front.sv =====
// ----------------------------------------------------------------------------
// gpe_front
// Accepts draw command requests, unpacks them and works out the linear
// address of the first cell row, then offers the command to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module gpe_front (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic [gpe_pkg::DIM_W-1:0]       frame_width,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [gpe_pkg::S_TDATA_W-1:0]   s_tdata,
  output logic                                 push_valid,
  input  wire logic                            push_ready,
  output gpe_pkg::cmd_t                        push_cmd
);

  localparam int PROD_W = gpe_pkg::DIM_W + gpe_pkg::COORD_W;

  logic                             stage_valid;
  gpe_pkg::cmd_t                    stage_cmd;
  gpe_pkg::cmd_t                    in_cmd;
  logic [PROD_W-1:0]                row_prod;
  logic                             load;

  // Unpack the request and multiply the top row by the frame stride.
  always_comb begin
    in_cmd.glyph_rows = s_tdata[gpe_pkg::GLYPH_W-1:0];
    in_cmd.pos_x      = s_tdata[75:64];
    in_cmd.pos_y      = s_tdata[87:76];
    in_cmd.fg_color   = s_tdata[119:88];
    in_cmd.bg_color   = s_tdata[151:120];
    row_prod          = PROD_W'(in_cmd.pos_y) * PROD_W'(frame_width);
    in_cmd.row_base   = row_prod[gpe_pkg::ADDR_W-1:0];
  end

  // The staging register frees up as soon as the queue takes its command.
  assign s_tready   = !stage_valid || push_ready;
  assign load       = s_tvalid && s_tready;
  assign push_valid = stage_valid;
  assign push_cmd   = stage_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (load) begin
      stage_valid <= 1'b1;
    end else if (push_ready) begin
      stage_valid <= 1'b0;
    end
    if (load) begin
      stage_cmd <= in_cmd;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/gpe_queue.sv =====
// ----------------------------------------------------------------------------
// gpe_queue
// Short first-in first-out command queue so that the front end and the
// pixel engine can stall independently.
// ----------------------------------------------------------------------------
`default_nettype none

module gpe_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push_valid,
  output logic               push_ready,
  input  wire gpe_pkg::cmd_t push_cmd,
  output logic               pop_valid,
  input  wire logic          pop_ready,
  output gpe_pkg::cmd_t      pop_cmd
);

  localparam logic [gpe_pkg::QUEUE_PTR_W-1:0] PTR_LAST =
    gpe_pkg::QUEUE_PTR_W'(gpe_pkg::QUEUE_DEPTH - 1);
  localparam logic [gpe_pkg::QUEUE_CNT_W-1:0] CNT_FULL =
    gpe_pkg::QUEUE_CNT_W'(gpe_pkg::QUEUE_DEPTH);

  gpe_pkg::cmd_t                       entries [gpe_pkg::QUEUE_DEPTH];
  logic [gpe_pkg::QUEUE_PTR_W-1:0]     wr_ptr;
  logic [gpe_pkg::QUEUE_PTR_W-1:0]     rd_ptr;
  logic [gpe_pkg::QUEUE_CNT_W-1:0]     count;
  logic                                do_push;
  logic                                do_pop;

  assign push_ready = (count != CNT_FULL);
  assign pop_valid  = (count != '0);
  assign pop_cmd    = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/gpe_back.sv =====
// ----------------------------------------------------------------------------
// gpe_back
// Pixel engine: walks one command's 64 glyph bits in row-major order, one
// pixel per cycle unless the output stalls, checks each pixel against the
// frame, stops at the first miss and keeps the dirty list of completed cells.
// ----------------------------------------------------------------------------
`default_nettype none

module gpe_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [gpe_pkg::DIM_W-1:0]     frame_width,
  input  wire logic [gpe_pkg::DIM_W-1:0]     frame_height,
  input  wire logic                          pop_valid,
  output logic                               pop_ready,
  input  wire gpe_pkg::cmd_t                 pop_cmd,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic                               m_tlast,
  output logic                               write_valid,
  output logic [gpe_pkg::ADDR_W-1:0]         write_address,
  output logic [gpe_pkg::COLOR_W-1:0]        write_color,
  output logic                               status,
  output logic                               dirty_stored
);

  localparam logic [gpe_pkg::DIRTY_FILL_W-1:0] FILL_MAX =
    gpe_pkg::DIRTY_FILL_W'(gpe_pkg::DIRTY_DEPTH);

  logic                                active;
  gpe_pkg::cmd_t                       cmd;
  logic [gpe_pkg::CELL_W-1:0]          row;
  logic [gpe_pkg::CELL_W-1:0]          col;
  logic [gpe_pkg::ADDR_W-1:0]          row_base;
  logic [gpe_pkg::DIRTY_FILL_W-1:0]    dirty_fill;
  logic [gpe_pkg::ADDR_W-1:0]          dirty_positions [gpe_pkg::DIRTY_DEPTH];

  logic [gpe_pkg::DIM_W-1:0]           pix_x;
  logic [gpe_pkg::DIM_W-1:0]           pix_y;
  logic                                out_of_frame;
  logic                                final_px;
  logic                                advance;
  logic                                finish;
  logic                                store;
  logic [gpe_pkg::ADDR_W-1:0]          pix_addr;
  logic                                glyph_bit;

  // Current pixel coordinates, bounds check and address.
  always_comb begin
    pix_x        = gpe_pkg::DIM_W'(cmd.pos_x) + gpe_pkg::DIM_W'(col);
    pix_y        = gpe_pkg::DIM_W'(cmd.pos_y) + gpe_pkg::DIM_W'(row);
    out_of_frame = (pix_x >= frame_width) || (pix_y >= frame_height);
    final_px     = (&row) && (&col);
    pix_addr     = row_base + gpe_pkg::ADDR_W'(pix_x);
    glyph_bit    = cmd.glyph_rows[{row, col}];
  end

  // One pixel leaves whenever the output register is free or being drained.
  assign advance   = active && (!m_tvalid || m_tready);
  assign finish    = advance && (out_of_frame || final_px);
  assign store     = final_px && !out_of_frame && (dirty_fill < FILL_MAX);
  assign pop_ready = !active || finish;

  // Command sequencing.
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (pop_valid && pop_ready) begin
      active <= 1'b1;
    end else if (finish) begin
      active <= 1'b0;
    end
    if (pop_valid && pop_ready) begin
      cmd      <= pop_cmd;
      row      <= '0;
      col      <= '0;
      row_base <= pop_cmd.row_base;
    end else if (advance && !finish) begin
      col <= col + 1'b1;
      if (&col) begin
        row      <= row + 1'b1;
        row_base <= row_base + gpe_pkg::ADDR_W'(frame_width);
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (advance) begin
      write_valid   <= !out_of_frame;
      write_address <= out_of_frame ? '0 : pix_addr;
      write_color   <= out_of_frame ? '0 :
                       (glyph_bit ? cmd.fg_color : cmd.bg_color);
      m_tlast       <= out_of_frame || final_px;
      status        <= out_of_frame;
      dirty_stored  <= store;
    end
  end

  // Dirty list: fill count and entries.
  always_ff @(posedge clk) begin
    if (rst) begin
      dirty_fill <= '0;
    end else if (advance && store) begin
      dirty_fill <= dirty_fill + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && store) begin
      dirty_positions[dirty_fill[gpe_pkg::DIRTY_IDX_W-1:0]] <= {cmd.pos_y, cmd.pos_x};
    end
  end

  // A result that is not the last of its command carries no status flags.
  a_mid_flags_clear: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> !status && !dirty_stored)
    else $error("status or dirty flag set on a non-final result");

  // An aborted command never writes a pixel in its error result.
  a_abort_no_write: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && status |-> !write_valid && m_tlast)
    else $error("error result marked as a pixel write");

  // The dirty list never grows past its depth.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    dirty_fill <= FILL_MAX)
    else $error("dirty list fill count exceeds depth");

  // A stored completed cell moves the fill count and is reported on its result.
  a_fill_tracks_flag: assert property (@(posedge clk) disable iff (rst)
    advance && store |=> m_tvalid && dirty_stored && dirty_fill == $past(dirty_fill) + 1'b1)
    else $error("dirty list update not reflected on the result");

endmodule

`default_nettype wire

// ===== rtl/core/glyph_pixel_expander_top.sv =====
// ----------------------------------------------------------------------------
// glyph_pixel_expander_top
// 8x8 character cell blitter: turns glyph draw commands into pixel writes.
// ----------------------------------------------------------------------------
// Each draw command gives up to 64 pixel write results, one per clock cycle
// while the output is not stalled. The next command is taken in by the
// front end and queued while the current one is drawn, so consecutive
// characters follow without a gap.
// Results come in row-major order; the first pixel outside the frame ends the
// command with an error result. Frame size registers must only be written
// while no command is in flight.
`default_nettype none

module glyph_pixel_expander_top (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // Configuration write port.
  input  wire logic                            cfg_we,
  input  wire logic [gpe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [gpe_pkg::DIM_W-1:0]       cfg_data,
  // Command stream.
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // glyph_rows[63:0], pos_x[75:64], pos_y[87:76], fg_color[119:88],
  // bg_color[151:120]
  input  wire logic [gpe_pkg::S_TDATA_W-1:0]   s_tdata,
  // Result stream.
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // write_address[23:0], write_color[55:24], status[56], dirty_stored[57],
  // zero fill above
  output logic [gpe_pkg::M_TDATA_W-1:0]        m_tdata,
  // write_valid[0]
  output logic                                 m_tuser,
  output logic                                 m_tlast
);

  logic [gpe_pkg::DIM_W-1:0]    frame_width;
  logic [gpe_pkg::DIM_W-1:0]    frame_height;
  logic                         push_valid;
  logic                         push_ready;
  gpe_pkg::cmd_t                push_cmd;
  logic                         pop_valid;
  logic                         pop_ready;
  gpe_pkg::cmd_t                pop_cmd;
  logic [gpe_pkg::ADDR_W-1:0]   write_address;
  logic [gpe_pkg::COLOR_W-1:0]  write_color;
  logic                         status;
  logic                         dirty_stored;

  // Frame size registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= gpe_pkg::FRAME_WIDTH_RST;
      frame_height <= gpe_pkg::FRAME_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gpe_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        gpe_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  gpe_front u_front (
    .clk         (clk),
    .rst         (rst),
    .frame_width (frame_width),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_cmd    (push_cmd)
  );

  gpe_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  gpe_back u_back (
    .clk           (clk),
    .rst           (rst),
    .frame_width   (frame_width),
    .frame_height  (frame_height),
    .pop_valid     (pop_valid),
    .pop_ready     (pop_ready),
    .pop_cmd       (pop_cmd),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tlast       (m_tlast),
    .write_valid   (m_tuser),
    .write_address (write_address),
    .write_color   (write_color),
    .status        (status),
    .dirty_stored  (dirty_stored)
  );

  // Pack the result fields, lowest first.
  assign m_tdata = {6'b0, dirty_stored, status, write_color, write_address};

endmodule

`default_nettype wire
